// File: src/buffer_pool_with_index_fifo_top_defines.svh
// Assertion macros shared by the buffer pool RTL files.
`ifndef BUFFER_POOL_WITH_INDEX_FIFO_TOP_DEFINES_SVH
`define BUFFER_POOL_WITH_INDEX_FIFO_TOP_DEFINES_SVH

// Same-cycle check on clk, held off while rst_n is low.
`define BPIF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check on clk, held off while rst_n is low.
`define BPIF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bpif_pkg.sv
// Package with the shared types and constants of the buffer pool.
`timescale 1ns / 1ps
package bpif_pkg;

    // Pool size and the fixed index width of the payload fields.
    localparam int unsigned NUM_BUFFERS = 256;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned CNT_W       = $clog2(NUM_BUFFERS + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_ENQUEUE = 2'd2,
        OP_DEQUEUE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_NONE  = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Control from the sequencer to the free list or the ring.
    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
        idx_t push_idx;
    } mem_ctrl_t;

    // Status of the free list.
    typedef struct packed {
        idx_t top;
        logic empty;
    } fl_stat_t;

    // Status of the ring.
    typedef struct packed {
        idx_t rd_data;
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

// File: src/bpif_req_if.sv
// Request channel: operation and buffer index.
`timescale 1ns / 1ps
interface bpif_req_if;
    logic             valid;
    logic             ready;
    bpif_pkg::op_t    op;
    bpif_pkg::idx_t   buffer_index;

    modport source (output valid, output op, output buffer_index, input ready);
    modport sink (input valid, input op, input buffer_index, output ready);
endinterface

// File: src/bpif_rsp_if.sv
// Response channel: result index and status.
`timescale 1ns / 1ps
interface bpif_rsp_if;
    logic              valid;
    logic              ready;
    bpif_pkg::idx_t    result_index;
    bpif_pkg::status_t status;

    modport source (output valid, output result_index, output status, input ready);
    modport sink (input valid, input result_index, input status, output ready);
endinterface

// File: src/bpif_free_list.sv
// Free list of buffer indices, linked through a synchronous next-pointer memory.
`timescale 1ns / 1ps
module bpif_free_list (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpif_pkg::mem_ctrl_t  ctrl,
    output bpif_pkg::fl_stat_t   stat
);
    import bpif_pkg::*;
    `include "buffer_pool_with_index_fifo_top_defines.svh"

    idx_t                   link_mem [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] link_valid_reg;
    idx_t                   rd_data_reg;
    logic                   rd_valid_reg;
    idx_t                   rd_addr_reg;
    idx_t                   top_reg;
    cnt_t                   count_reg;
    idx_t                   next_link;

    // A link never written (valid bit clear) stands for the following index, wrapping to zero at the last.
    always_comb
    begin
        if (rd_valid_reg)
        begin
            next_link = rd_data_reg;
        end
        else if (32'(rd_addr_reg) == NUM_BUFFERS - 1)
        begin
            next_link = '0;
        end
        else
        begin
            next_link = rd_addr_reg + IDX_W'(1);
        end
    end

    // Link memory: read at the head, write on a push.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_data_reg <= link_mem[top_reg];
            rd_addr_reg <= top_reg;
        end
        if (ctrl.push)
        begin
            link_mem[ctrl.push_idx] <= top_reg;
        end
    end

    // Valid bits of the links, head pointer and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            top_reg        <= '0;
            count_reg      <= CNT_W'(NUM_BUFFERS);
        end
        else
        begin
            if (ctrl.rd)
            begin
                rd_valid_reg <= link_valid_reg[top_reg];
            end
            if (ctrl.push)
            begin
                link_valid_reg[ctrl.push_idx] <= 1'b1;
                top_reg <= ctrl.push_idx;
                if (32'(count_reg) < NUM_BUFFERS)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else if (ctrl.pop)
            begin
                top_reg   <= next_link;
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign stat.top   = top_reg;
    assign stat.empty = (count_reg == '0);

    `BPIF_ASSERT_NOW(a_fl_pop_nonempty, ctrl.pop, count_reg != '0,
        "free list popped while empty")
    `BPIF_ASSERT_NOW(a_fl_count_bound, 1'b1, 32'(count_reg) <= NUM_BUFFERS,
        "free list count beyond pool size")
    `BPIF_ASSERT_NXT(a_fl_push_top, ctrl.push, top_reg == $past(ctrl.push_idx),
        "pushed index did not become the head")
endmodule

// File: src/bpif_ring.sv
// Ring FIFO of buffer indices in a synchronous memory.
`timescale 1ns / 1ps
module bpif_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bpif_pkg::mem_ctrl_t   ctrl,
    output bpif_pkg::ring_stat_t  stat
);
    import bpif_pkg::*;
    `include "buffer_pool_with_index_fifo_top_defines.svh"

    idx_t slot_mem [NUM_BUFFERS];
    idx_t rd_data_reg;
    idx_t rd_ptr_reg;
    idx_t wr_ptr_reg;
    cnt_t count_reg;

    function automatic idx_t wrap_inc(input idx_t p);
        if (32'(p) == NUM_BUFFERS - 1)
        begin
            return '0;
        end
        return p + IDX_W'(1);
    endfunction

    // Slot memory: read at the read pointer, write at the write pointer.
    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            rd_data_reg <= slot_mem[rd_ptr_reg];
        end
        if (ctrl.push)
        begin
            slot_mem[wr_ptr_reg] <= ctrl.push_idx;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.push)
        begin
            wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            count_reg  <= count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            count_reg  <= count_reg - CNT_W'(1);
        end
    end

    assign stat.rd_data = rd_data_reg;
    assign stat.empty   = (count_reg == '0);
    assign stat.full    = (32'(count_reg) >= NUM_BUFFERS);

    `BPIF_ASSERT_NOW(a_ring_pop_nonempty, ctrl.pop, count_reg != '0,
        "ring popped while empty")
    `BPIF_ASSERT_NOW(a_ring_push_notfull, ctrl.push, 32'(count_reg) < NUM_BUFFERS,
        "ring pushed while full")
    `BPIF_ASSERT_NOW(a_ring_ptr_count, count_reg == '0, rd_ptr_reg == wr_ptr_reg,
        "empty ring with pointers apart")
endmodule

// File: src/buffer_pool_with_index_fifo_top.sv
// Top level of the buffer pool with index FIFO: sequencer and response register.
`timescale 1ns / 1ps
// Each request beat passes through S_IDLE and S_EXEC: the accept edge reads the free-list
// link at the head and the ring slot at the read pointer from their memories, and
// the commit edge in S_EXEC uses that registered read data to form the response and
// write the free list, ring and pointers back. A new request is taken only after that
// commit, once the sequencer is back in S_IDLE. The response sits in its own register,
// so a request is accepted while the previous response still waits; a stalled
// response holds the commit of the following operation.
// No clearing pass runs after reset: the pool is ready as soon as reset is released.
module buffer_pool_with_index_fifo_top (
    input  logic        clk,
    input  logic        rst_n,
    bpif_req_if.sink    req,
    bpif_rsp_if.source  rsp
);
    import bpif_pkg::*;
    `include "buffer_pool_with_index_fifo_top_defines.svh"

    state_t     state_reg;
    state_t     state_next;
    op_t        op_reg;
    idx_t       idx_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    idx_t       rsp_index_reg;
    status_t    rsp_status_reg;
    logic       accept;
    logic       commit;
    logic       in_range;
    idx_t       res_index;
    status_t    res_status;
    mem_ctrl_t  fl_ctrl;
    mem_ctrl_t  ring_ctrl;
    fl_stat_t   fl_stat;
    ring_stat_t ring_stat;

    bpif_free_list u_free_list (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fl_ctrl),
        .stat  (fl_stat)
    );

    bpif_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ring_ctrl),
        .stat  (ring_stat)
    );

    assign accept   = req.valid && req.ready;
    assign in_range = (32'(idx_reg) < NUM_BUFFERS);

    // Result of the held operation from the range check and the free-list and ring status.
    always_comb
    begin
        res_index  = '0;
        res_status = STAT_OK;
        case (op_reg)
            OP_ALLOC:
            begin
                if (fl_stat.empty)
                begin
                    res_status = STAT_NONE;
                end
                else
                begin
                    res_index = fl_stat.top;
                end
            end
            OP_FREE:
            begin
                if (!in_range)
                begin
                    res_status = STAT_RANGE;
                end
            end
            OP_ENQUEUE:
            begin
                if (!in_range)
                begin
                    res_status = STAT_RANGE;
                end
                else if (ring_stat.full)
                begin
                    res_status = STAT_FULL;
                end
            end
            OP_DEQUEUE:
            begin
                if (ring_stat.empty)
                begin
                    res_status = STAT_NONE;
                end
                else
                begin
                    res_index = ring_stat.rd_data;
                end
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
    end

    // Sequencer: next state, handshake and memory control.
    always_comb
    begin
        state_next      = state_reg;
        req.ready       = 1'b0;
        commit          = 1'b0;
        fl_ctrl         = '0;
        ring_ctrl       = '0;
        fl_ctrl.push_idx   = idx_reg;
        ring_ctrl.push_idx = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    fl_ctrl.rd   = 1'b1;
                    ring_ctrl.rd = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    commit         = 1'b1;
                    fl_ctrl.pop    = (op_reg == OP_ALLOC) && (res_status == STAT_OK);
                    fl_ctrl.push   = (op_reg == OP_FREE) && (res_status == STAT_OK);
                    ring_ctrl.push = (op_reg == OP_ENQUEUE) && (res_status == STAT_OK);
                    ring_ctrl.pop  = (op_reg == OP_DEQUEUE) && (res_status == STAT_OK);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid: set on commit, cleared once the beat is taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request and response payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req.op;
            idx_reg <= req.buffer_index;
        end
        if (commit)
        begin
            rsp_index_reg  <= res_index;
            rsp_status_reg <= res_status;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_index = rsp_index_reg;
    assign rsp.status       = rsp_status_reg;

    `BPIF_ASSERT_NXT(a_top_accept_exec, accept, state_reg == S_EXEC,
        "accepted request did not enter execution")
    `BPIF_ASSERT_NXT(a_top_commit_valid, commit, rsp_valid_reg,
        "committed operation left no response")
    `BPIF_ASSERT_NOW(a_top_err_zero, rsp_valid_reg && (rsp_status_reg != STAT_OK),
        rsp_index_reg == '0, "failed operation returned a nonzero index")
endmodule

// File: sim/bpif_response_checker.sv
// Checker that predicts buffer pool responses from request beats and compares them.
`timescale 1ns / 1ps
module bpif_response_checker (
    input  logic clk,
    input  logic rst_n,
    bpif_req_if  req_mon,
    bpif_rsp_if  rsp_mon,
    output int   errors,
    output int   pending
);
    import bpif_pkg::*;

    typedef struct packed {
        idx_t    result_index;
        status_t status;
    } pool_rsp_t;

    // Own copy of the free list and the index ring.
    idx_t      link_mem [NUM_BUFFERS];
    idx_t      list_head;
    cnt_t      free_total;
    idx_t      ring_mem [NUM_BUFFERS];
    idx_t      ring_rd;
    idx_t      ring_wr;
    cnt_t      ring_fill;
    pool_rsp_t awaited_rsp_q [$];
    int        fail_count = 0;

    assign errors = fail_count;

    function automatic idx_t next_slot(input idx_t p);
        return (p == idx_t'(NUM_BUFFERS - 1)) ? idx_t'(0) : idx_t'(p + 1'b1);
    endfunction

    // The free list chains every index in ascending order after reset.
    task automatic pool_clear();
        for (int i = 0; i < NUM_BUFFERS; i++)
        begin
            link_mem[i] = next_slot(idx_t'(i));
            ring_mem[i] = '0;
        end
        list_head  = '0;
        free_total = cnt_t'(NUM_BUFFERS);
        ring_rd    = '0;
        ring_wr    = '0;
        ring_fill  = '0;
        awaited_rsp_q.delete();
    endtask

    // Apply one operation to the pool state and return the response it gives.
    function automatic pool_rsp_t pool_apply(input op_t op_val, input idx_t idx_val);
        pool_rsp_t r;
        r.result_index = '0;
        r.status       = STAT_OK;
        case (op_val)
            OP_ALLOC:
            begin
                if (free_total == 0)
                begin
                    r.status = STAT_NONE;
                end
                else
                begin
                    r.result_index = list_head;
                    list_head      = link_mem[list_head];
                    free_total     = free_total - 1'b1;
                end
            end
            OP_FREE:
            begin
                if (idx_val >= NUM_BUFFERS)
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    // A double free is pushed again; the count saturates.
                    link_mem[idx_val] = list_head;
                    list_head         = idx_val;
                    if (free_total < NUM_BUFFERS)
                        free_total = free_total + 1'b1;
                end
            end
            OP_ENQUEUE:
            begin
                if (idx_val >= NUM_BUFFERS)
                    r.status = STAT_RANGE;
                else if (ring_fill >= NUM_BUFFERS)
                    r.status = STAT_FULL;
                else
                begin
                    ring_mem[ring_wr] = idx_val;
                    ring_wr           = next_slot(ring_wr);
                    ring_fill         = ring_fill + 1'b1;
                end
            end
            default:
            begin
                if (ring_fill == 0)
                begin
                    r.status = STAT_NONE;
                end
                else
                begin
                    r.result_index = ring_mem[ring_rd];
                    ring_rd        = next_slot(ring_rd);
                    ring_fill      = ring_fill - 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_failure(input string what, input pool_rsp_t want);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected index %0d status %0d, got index %0d status %0d",
                     $realtime, what, want.result_index, want.status,
                     rsp_mon.result_index, rsp_mon.status);
    endtask

    // Predict on every request beat, compare on every response beat.
    always @(posedge clk or negedge rst_n)
    begin
        pool_rsp_t want;
        if (!rst_n)
        begin
            pool_clear();
            pending <= 0;
        end
        else
        begin
            if (req_mon.valid && req_mon.ready)
                awaited_rsp_q.push_back(pool_apply(req_mon.op, req_mon.buffer_index));
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (awaited_rsp_q.size() == 0)
                begin
                    want = '0;
                    report_failure("response beat with none awaited", want);
                end
                else
                begin
                    want = awaited_rsp_q.pop_front();
                    if (rsp_mon.result_index !== want.result_index ||
                        rsp_mon.status !== want.status)
                        report_failure("response mismatch", want);
                end
            end
            pending <= awaited_rsp_q.size();
        end
    end

endmodule

// File: sim/buffer_pool_with_index_fifo_top_tb.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps
module buffer_pool_with_index_fifo_top_tb;
    import bpif_pkg::*;

    localparam int LONG_HOLD = 120;

    logic clk;
    logic rst_n;
    int   errors;
    int   rsp_pending;
    bit   sender_idle_on = 1'b1;
    bit   long_hold_req  = 1'b0;

    bpif_req_if req_ch ();
    bpif_rsp_if rsp_ch ();

    buffer_pool_with_index_fifo_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bpif_response_checker rsp_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_mon (req_ch),
        .rsp_mon (rsp_ch),
        .errors  (errors),
        .pending (rsp_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Choose an operation by relative weights.
    function automatic op_t pick_op(input int wa, input int wf, input int we, input int wd);
        int r;
        r = $urandom_range(0, wa + wf + we + wd - 1);
        if (r < wa)
            return OP_ALLOC;
        else if (r < wa + wf)
            return OP_FREE;
        else if (r < wa + wf + we)
            return OP_ENQUEUE;
        return OP_DEQUEUE;
    endfunction

    function automatic idx_t any_index();
        return idx_t'($urandom_range(0, 255));
    endfunction

    // Offer one request beat and hold it until the block takes it.
    task automatic send_beat(input op_t op_val, input idx_t idx_val);
        int gap;
        gap = sender_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op_val;
        req_ch.buffer_index <= idx_val;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Stop offering and wait until every awaited response has arrived.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (rsp_pending != 0);
    endtask

    // Response side: random ready stretches, plus one long hold on request.
    initial
    begin
        int run;
        int stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 20);
                rsp_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = pick_gap();
                if (stall > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Request stimulus and verdict.
    initial
    begin
        int wa;
        int wf;
        int we;
        int wd;
        op_t op_val;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_ALLOC;
        req_ch.buffer_index <= '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty ring, allocation order, double free and saturation.
        send_beat(OP_DEQUEUE, 8'hFF);
        send_beat(OP_ALLOC,   8'h00);
        send_beat(OP_ALLOC,   8'hFF);
        send_beat(OP_FREE,    8'hFF);
        send_beat(OP_ALLOC,   8'h00);
        send_beat(OP_FREE,    8'h00);
        send_beat(OP_FREE,    8'h01);
        send_beat(OP_ALLOC,   8'h5A);
        send_beat(OP_ENQUEUE, 8'h00);
        send_beat(OP_ENQUEUE, 8'hFF);
        send_beat(OP_ENQUEUE, 8'hAA);
        send_beat(OP_ENQUEUE, 8'h55);
        repeat (4) send_beat(OP_DEQUEUE, 8'h00);
        send_beat(OP_DEQUEUE, 8'h00);
        send_beat(OP_FREE,    8'h00);
        send_beat(OP_FREE,    8'h00);
        send_beat(OP_ALLOC,   8'hFF);
        send_beat(OP_ALLOC,   8'h00);

        // Drain the pool past empty with no sender idling.
        sender_idle_on = 1'b0;
        repeat (258) send_beat(OP_ALLOC, any_index());

        // Fill the ring past full, then pause until everything has come back.
        sender_idle_on = 1'b1;
        repeat (258) send_beat(OP_ENQUEUE, any_index());
        wait_drained();

        // Empty the ring past empty, then return random indices to the pool.
        repeat (258) send_beat(OP_DEQUEUE, any_index());
        repeat (100) send_beat(OP_FREE, any_index());

        // Mixed traffic in phases with different operation weights.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin wa = 1; wf = 1; we = 1; wd = 1; end
                1:       begin wa = 3; wf = 1; we = 3; wd = 1; end
                2:       begin wa = 1; wf = 3; we = 1; wd = 3; end
                default: begin wa = 2; wf = 2; we = 2; wd = 2; end
            endcase
            // In the second phase the receiver holds off while requests keep coming.
            sender_idle_on = (phase != 1);
            if (phase == 1)
                long_hold_req = 1'b1;
            repeat (125)
            begin
                op_val = pick_op(wa, wf, we, wd);
                send_beat(op_val, any_index());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("buffer_pool_with_index_fifo_top regression: pass");
        else
            $display("buffer_pool_with_index_fifo_top regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #20_000_000;
        $display("buffer_pool_with_index_fifo_top regression: fail");
        $finish;
    end

endmodule
